// ===== hdl/tfr8_pkg.sv =====
// tfr8_pkg: format codes, stage structs and conversion functions
// for the texel format unpack pipeline; no dependencies

package tfr8_pkg;

	localparam logic [4:0] FMT_RGBA8   = 5'd0;
	localparam logic [4:0] FMT_565     = 5'd1;
	localparam logic [4:0] FMT_5551    = 5'd2;
	localparam logic [4:0] FMT_4444    = 5'd3;
	localparam logic [4:0] FMT_SNORM2  = 5'd4;
	localparam logic [4:0] FMT_SNORM4  = 5'd5;
	localparam logic [4:0] FMT_1010102 = 5'd6;
	localparam logic [4:0] FMT_RG16    = 5'd7;
	localparam logic [4:0] FMT_RGBA16  = 5'd8;
	localparam logic [4:0] FMT_A8      = 5'd9;
	localparam logic [4:0] FMT_F32X1   = 5'd10;
	localparam logic [4:0] FMT_F32X2   = 5'd11;
	localparam logic [4:0] FMT_F32X4   = 5'd12;
	localparam logic [4:0] FMT_F16X1   = 5'd13;
	localparam logic [4:0] FMT_F16X2   = 5'd14;
	localparam logic [4:0] FMT_F16X4   = 5'd15;

	// lane conversion kinds
	localparam logic [2:0] LK_RAW   = 3'd0; // byte passes through
	localparam logic [2:0] LK_UNORM = 3'd1; // n*255/dmax rounded
	localparam logic [2:0] LK_F32   = 3'd2;
	localparam logic [2:0] LK_F16   = 3'd3;
	localparam logic [2:0] LK_CONST = 3'd4; // constant byte

	// per-lane work after stage 1: a value, a kind and its unorm width
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] bits;
		logic [4:0]  nbits; // unorm field width 1..16
	} lane_t;

	// per-lane after stage 2: a fixed-point product and shift
	typedef struct packed {
		logic        is_const;
		logic [7:0]  cval;
		logic [39:0] prod;  // value * 255, or unorm field * reciprocal
		logic [5:0]  shift; // result = (prod + half) >> shift
	} lane2_t;

	// unorm n of width w: round half up of n*255/(2^w-1) equals
	// (n*c + 2^(2w-1)) >> 2w with c = round(255*4^w/(2^w-1));
	// the error stays below 1/(2*dmax) because 4^w > dmax^2
	function automatic logic [24:0] unorm_mult(input logic [4:0] w);
		logic [24:0] c;
		case (w)
			5'd2:    c = 25'd1360;
			5'd4:    c = 25'd4352;
			5'd5:    c = 25'd8423;
			5'd6:    c = 25'd16579;
			5'd7:    c = 25'd32897;
			5'd10:   c = 25'd261375;
			5'd16:   c = 25'd16711935;
			default: c = 25'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/texel_format_to_rgba8_unit.sv =====
// texel_format_to_rgba8_unit: four-stage pipeline unpacking one texel into rgba8
// depends on tfr8_pkg
//
// throughput: one beat per cycle, stall freezes every stage together
// reset: arst_n clears valid bits and missing_fill; payload regs are not reset
// stages: decode and field extract / float classify, multiply by 255 and
//   unorm multiply by reciprocal / round half up and shift / output register

module texel_format_to_rgba8_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  mode,
	input  logic [63:0] texel_low,
	input  logic [63:0] texel_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        unsupported
);

	logic missing_fill_q;
	logic adv; // whole pipe moves

	logic v_s1, v_s2, v_s3, v_s4;
	tfr8_pkg::lane_t  ln_s1 [4];
	tfr8_pkg::lane_t  ln_c  [4];
	tfr8_pkg::lane2_t l2_s2 [4];
	tfr8_pkg::lane2_t l2_c  [4];
	logic [7:0]       by_s3 [4];
	logic [7:0]       by_c  [4];
	logic bad_s1, bad_s2, bad_s3;
	logic [7:0] fill;

	// stall whenever an output beat waits, bubbles behind it or not
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_fill_q <= 1'b0;
		end else if (cfg_we) begin
			missing_fill_q <= cfg_wdata;
		end
	end

	assign fill = missing_fill_q ? 8'hFF : 8'h00;

	// ---- stage 1: decode the format into four lane jobs
	function automatic tfr8_pkg::lane_t mk(input logic [2:0] k, input logic [31:0] b,
		input logic [4:0] w);
		tfr8_pkg::lane_t l;
		l.kind = k; l.bits = b; l.nbits = w;
		return l;
	endfunction

	// signed byte to a 7-bit unorm field: non-positive becomes zero
	function automatic logic [31:0] sn(input logic [7:0] b);
		return (b[7] || b == 8'd0) ? 32'd0 : {25'd0, b[6:0]};
	endfunction

	always_comb begin
		logic [31:0] w0, w1;
		w0 = texel_low[31:0];
		w1 = texel_low[63:32];
		ln_c[0] = mk(tfr8_pkg::LK_CONST, 32'd0, 5'd1);
		ln_c[1] = mk(tfr8_pkg::LK_CONST, 32'd0, 5'd1);
		ln_c[2] = mk(tfr8_pkg::LK_CONST, 32'd0, 5'd1);
		ln_c[3] = mk(tfr8_pkg::LK_CONST, 32'd255, 5'd1);
		unique case (mode)
			tfr8_pkg::FMT_RGBA8: begin
				ln_c[0] = mk(tfr8_pkg::LK_RAW, {24'd0, w0[7:0]}, 5'd8);
				ln_c[1] = mk(tfr8_pkg::LK_RAW, {24'd0, w0[15:8]}, 5'd8);
				ln_c[2] = mk(tfr8_pkg::LK_RAW, {24'd0, w0[23:16]}, 5'd8);
				ln_c[3] = mk(tfr8_pkg::LK_RAW, {24'd0, w0[31:24]}, 5'd8);
			end
			tfr8_pkg::FMT_565: begin
				ln_c[0] = mk(tfr8_pkg::LK_UNORM, {27'd0, w0[15:11]}, 5'd5);
				ln_c[1] = mk(tfr8_pkg::LK_UNORM, {26'd0, w0[10:5]}, 5'd6);
				ln_c[2] = mk(tfr8_pkg::LK_UNORM, {27'd0, w0[4:0]}, 5'd5);
			end
			tfr8_pkg::FMT_5551: begin
				ln_c[0] = mk(tfr8_pkg::LK_UNORM, {27'd0, w0[14:10]}, 5'd5);
				ln_c[1] = mk(tfr8_pkg::LK_UNORM, {27'd0, w0[9:5]}, 5'd5);
				ln_c[2] = mk(tfr8_pkg::LK_UNORM, {27'd0, w0[4:0]}, 5'd5);
				ln_c[3] = mk(tfr8_pkg::LK_CONST, w0[15] ? 32'd255 : 32'd0, 5'd1);
			end
			tfr8_pkg::FMT_4444: begin
				ln_c[0] = mk(tfr8_pkg::LK_UNORM, {28'd0, w0[11:8]}, 5'd4);
				ln_c[1] = mk(tfr8_pkg::LK_UNORM, {28'd0, w0[7:4]}, 5'd4);
				ln_c[2] = mk(tfr8_pkg::LK_UNORM, {28'd0, w0[3:0]}, 5'd4);
				ln_c[3] = mk(tfr8_pkg::LK_UNORM, {28'd0, w0[15:12]}, 5'd4);
			end
			tfr8_pkg::FMT_SNORM2: begin
				ln_c[0] = mk(tfr8_pkg::LK_UNORM, sn(w0[7:0]), 5'd7);
				ln_c[1] = mk(tfr8_pkg::LK_UNORM, sn(w0[15:8]), 5'd7);
				ln_c[2] = mk(tfr8_pkg::LK_CONST, {24'd0, fill}, 5'd1);
			end
			tfr8_pkg::FMT_SNORM4: begin
				ln_c[0] = mk(tfr8_pkg::LK_UNORM, sn(w0[7:0]), 5'd7);
				ln_c[1] = mk(tfr8_pkg::LK_UNORM, sn(w0[15:8]), 5'd7);
				ln_c[2] = mk(tfr8_pkg::LK_UNORM, sn(w0[23:16]), 5'd7);
				ln_c[3] = mk(tfr8_pkg::LK_UNORM, sn(w0[31:24]), 5'd7);
			end
			tfr8_pkg::FMT_1010102: begin
				ln_c[0] = mk(tfr8_pkg::LK_UNORM, {22'd0, w0[9:0]}, 5'd10);
				ln_c[1] = mk(tfr8_pkg::LK_UNORM, {22'd0, w0[19:10]}, 5'd10);
				ln_c[2] = mk(tfr8_pkg::LK_UNORM, {22'd0, w0[29:20]}, 5'd10);
				ln_c[3] = mk(tfr8_pkg::LK_UNORM, {30'd0, w0[31:30]}, 5'd2);
			end
			tfr8_pkg::FMT_RG16: begin
				ln_c[0] = mk(tfr8_pkg::LK_UNORM, {16'd0, w0[15:0]}, 5'd16);
				ln_c[1] = mk(tfr8_pkg::LK_UNORM, {16'd0, w0[31:16]}, 5'd16);
				ln_c[2] = mk(tfr8_pkg::LK_CONST, {24'd0, fill}, 5'd1);
			end
			tfr8_pkg::FMT_RGBA16: begin
				ln_c[0] = mk(tfr8_pkg::LK_UNORM, {16'd0, w0[15:0]}, 5'd16);
				ln_c[1] = mk(tfr8_pkg::LK_UNORM, {16'd0, w0[31:16]}, 5'd16);
				ln_c[2] = mk(tfr8_pkg::LK_UNORM, {16'd0, w1[15:0]}, 5'd16);
				ln_c[3] = mk(tfr8_pkg::LK_UNORM, {16'd0, w1[31:16]}, 5'd16);
			end
			tfr8_pkg::FMT_A8: begin
				ln_c[3] = mk(tfr8_pkg::LK_RAW, {24'd0, w0[7:0]}, 5'd8);
			end
			tfr8_pkg::FMT_F32X1: begin
				ln_c[0] = mk(tfr8_pkg::LK_F32, w0, 5'd1);
				ln_c[1] = mk(tfr8_pkg::LK_CONST, {24'd0, fill}, 5'd1);
				ln_c[2] = mk(tfr8_pkg::LK_CONST, {24'd0, fill}, 5'd1);
			end
			tfr8_pkg::FMT_F32X2: begin
				ln_c[0] = mk(tfr8_pkg::LK_F32, w0, 5'd1);
				ln_c[1] = mk(tfr8_pkg::LK_F32, w1, 5'd1);
				ln_c[2] = mk(tfr8_pkg::LK_CONST, {24'd0, fill}, 5'd1);
			end
			tfr8_pkg::FMT_F32X4: begin
				ln_c[0] = mk(tfr8_pkg::LK_F32, w0, 5'd1);
				ln_c[1] = mk(tfr8_pkg::LK_F32, w1, 5'd1);
				ln_c[2] = mk(tfr8_pkg::LK_F32, texel_high[31:0], 5'd1);
				ln_c[3] = mk(tfr8_pkg::LK_F32, texel_high[63:32], 5'd1);
			end
			tfr8_pkg::FMT_F16X1: begin
				ln_c[0] = mk(tfr8_pkg::LK_F16, {16'd0, w0[15:0]}, 5'd1);
				ln_c[1] = mk(tfr8_pkg::LK_CONST, {24'd0, fill}, 5'd1);
				ln_c[2] = mk(tfr8_pkg::LK_CONST, {24'd0, fill}, 5'd1);
			end
			tfr8_pkg::FMT_F16X2: begin
				ln_c[0] = mk(tfr8_pkg::LK_F16, {16'd0, w0[15:0]}, 5'd1);
				ln_c[1] = mk(tfr8_pkg::LK_F16, {16'd0, w0[31:16]}, 5'd1);
				ln_c[2] = mk(tfr8_pkg::LK_CONST, {24'd0, fill}, 5'd1);
			end
			tfr8_pkg::FMT_F16X4: begin
				ln_c[0] = mk(tfr8_pkg::LK_F16, {16'd0, w0[15:0]}, 5'd1);
				ln_c[1] = mk(tfr8_pkg::LK_F16, {16'd0, w0[31:16]}, 5'd1);
				ln_c[2] = mk(tfr8_pkg::LK_F16, {16'd0, w1[15:0]}, 5'd1);
				ln_c[3] = mk(tfr8_pkg::LK_F16, {16'd0, w1[31:16]}, 5'd1);
			end
			default: begin
				// unsupported code: every channel zero
				ln_c[3] = mk(tfr8_pkg::LK_CONST, 32'd0, 5'd1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ln_s1  <= ln_c;
			bad_s1 <= mode[4];
		end
	end

	// ---- stage 2: classify floats, form mantissa * 255 or unorm * reciprocal
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic [7:0]  e8;
			logic [4:0]  e5;
			logic [31:0] b;
			logic [23:0] m;
			logic [8:0]  s;
			b = ln_s1[i].bits;
			e8 = b[30:23];
			e5 = b[14:10];
			m = 24'd0;
			s = 9'd0;
			l2_c[i].is_const = 1'b1;
			l2_c[i].cval     = b[7:0];
			l2_c[i].prod     = 40'd0;
			l2_c[i].shift    = 6'd0;
			case (ln_s1[i].kind)
				tfr8_pkg::LK_UNORM: begin
					l2_c[i].is_const = 1'b0;
					l2_c[i].prod  = 40'(b[15:0]) *
						40'(tfr8_pkg::unorm_mult(ln_s1[i].nbits));
					l2_c[i].shift = {ln_s1[i].nbits, 1'b0};
				end
				tfr8_pkg::LK_F32: begin
					if (b[31] || e8 == 8'd0 || (e8 == 8'hFF && b[22:0] != 23'd0)) begin
						l2_c[i].cval = 8'd0;
					end else if (e8 >= 8'd127) begin
						l2_c[i].cval = 8'd255;
					end else begin
						s = 9'd150 - {1'b0, e8};
						if (s >= 9'd40) begin
							l2_c[i].cval = 8'd0;
						end else begin
							m = {1'b1, b[22:0]};
							l2_c[i].is_const = 1'b0;
							l2_c[i].prod  = 40'(m) * 40'd255;
							l2_c[i].shift = s[5:0];
						end
					end
				end
				tfr8_pkg::LK_F16: begin
					if (b[15] || (e5 == 5'h1F && b[9:0] != 10'd0)) begin
						l2_c[i].cval = 8'd0;
					end else if (e5 >= 5'd15) begin
						l2_c[i].cval = 8'd255;
					end else if (e5 == 5'd0) begin
						l2_c[i].is_const = 1'b0;
						l2_c[i].prod  = 40'(b[9:0]) * 40'd255;
						l2_c[i].shift = 6'd24;
					end else begin
						l2_c[i].is_const = 1'b0;
						l2_c[i].prod  = 40'({1'b1, b[9:0]}) * 40'd255;
						l2_c[i].shift = 6'(5'd25 - e5);
					end
				end
				default: begin
					// raw and constant bytes pass as they are
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l2_s2  <= l2_c;
			bad_s2 <= bad_s1;
		end
	end

	// ---- stage 3: round half up and shift down
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic [40:0] sum;
			sum = 41'(l2_s2[i].prod) + (41'd1 << (l2_s2[i].shift - 6'd1));
			by_c[i] = l2_s2[i].is_const ? l2_s2[i].cval : 8'(sum >> l2_s2[i].shift);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			by_s3  <= by_c;
			bad_s3 <= bad_s2;
		end
	end

	// ---- stage 4: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red         <= by_s3[0];
			green       <= by_s3[1];
			blue        <= by_s3[2];
			alpha       <= by_s3[3];
			unsupported <= bad_s3;
		end
	end

	assign out_valid = v_s4;

	// a stalled output beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(alpha))
		else $error("output beat changed under stall");

	// unsupported beats carry zero channels
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> red == 8'd0 && green == 8'd0 &&
		blue == 8'd0 && alpha == 8'd0)
		else $error("unsupported beat with nonzero channel");

	// input is stalled exactly when the output beat is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("stall mismatch");

	// a beat accepted and followed by no stall reaches the output
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
		else $error("beat lost in pipe");

endmodule

// ===== tb/texel_checker.sv =====
// texel_checker: watches the texel in and rgba8 out channels, predicts each
// decoded pixel and compares it beat by beat; depends on tfr8_pkg
`timescale 1ns / 1ps

module texel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [4:0]  mode,
	input  logic [63:0] texel_low,
	input  logic [63:0] texel_high,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	input  logic        unsupported,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       bad;
	} pixel_t;

	pixel_t pixel_q[$];
	logic   fill_on;

	assign pending = pixel_q.size();

	function automatic logic [7:0] unorm8(input logic [31:0] n, input logic [31:0] dmax);
		return 8'((n * 510 + dmax) / (2 * dmax));
	endfunction

	function automatic logic [7:0] frac8(input logic [31:0] mant, input int s);
		logic [63:0] p;
		if (s >= 40) return 8'd0;
		p = 64'(mant) * 255 + (64'd1 << (s - 1));
		return 8'(p >> s);
	endfunction

	function automatic logic [7:0] snorm8(input logic [7:0] v);
		if (v == 0 || v >= 128) return 8'd0;
		return unorm8(v, 127);
	endfunction

	function automatic logic [7:0] f32_8(input logic [31:0] x);
		if (x[30:23] == 8'hFF && x[22:0] != 0) return 8'd0;
		if (x[31]) return 8'd0;
		if (x[30:23] >= 127) return 8'd255;
		if (x[30:23] == 0) return 8'd0;
		return frac8({9'd1, x[22:0]}, 150 - x[30:23]);
	endfunction

	function automatic logic [7:0] f16_8(input logic [15:0] x);
		if (x[14:10] == 5'h1F && x[9:0] != 0) return 8'd0;
		if (x[15]) return 8'd0;
		if (x[14:10] >= 15) return 8'd255;
		if (x[14:10] == 0) return x[9:0] == 0 ? 8'd0 : frac8(x[9:0], 24);
		return frac8({22'd1, x[9:0]}, 25 - x[14:10]);
	endfunction

	function automatic pixel_t decode_texel(input logic [4:0] m, input logic [63:0] lo,
			input logic [63:0] hi, input logic fl);
		pixel_t p;
		logic [7:0] f;
		f = fl ? 8'd255 : 8'd0;
		p = '{r: 0, g: 0, b: 0, a: 255, bad: 0};
		case (m)
			tfr8_pkg::FMT_RGBA8: p = '{lo[7:0], lo[15:8], lo[23:16], lo[31:24], 1'b0};
			tfr8_pkg::FMT_565: begin
				p.r = unorm8(lo[15:11], 31); p.g = unorm8(lo[10:5], 63);
				p.b = unorm8(lo[4:0], 31);
			end
			tfr8_pkg::FMT_5551: begin
				p.r = unorm8(lo[14:10], 31); p.g = unorm8(lo[9:5], 31);
				p.b = unorm8(lo[4:0], 31); p.a = lo[15] ? 8'd255 : 8'd0;
			end
			tfr8_pkg::FMT_4444: begin
				p.r = unorm8(lo[11:8], 15); p.g = unorm8(lo[7:4], 15);
				p.b = unorm8(lo[3:0], 15); p.a = unorm8(lo[15:12], 15);
			end
			tfr8_pkg::FMT_SNORM2: begin
				p.r = snorm8(lo[7:0]); p.g = snorm8(lo[15:8]); p.b = f;
			end
			tfr8_pkg::FMT_SNORM4: begin
				p.r = snorm8(lo[7:0]); p.g = snorm8(lo[15:8]);
				p.b = snorm8(lo[23:16]); p.a = snorm8(lo[31:24]);
			end
			tfr8_pkg::FMT_1010102: begin
				p.r = unorm8(lo[9:0], 1023); p.g = unorm8(lo[19:10], 1023);
				p.b = unorm8(lo[29:20], 1023); p.a = unorm8(lo[31:30], 3);
			end
			tfr8_pkg::FMT_RG16: begin
				p.r = unorm8(lo[15:0], 65535); p.g = unorm8(lo[31:16], 65535); p.b = f;
			end
			tfr8_pkg::FMT_RGBA16: begin
				p.r = unorm8(lo[15:0], 65535); p.g = unorm8(lo[31:16], 65535);
				p.b = unorm8(lo[47:32], 65535); p.a = unorm8(lo[63:48], 65535);
			end
			tfr8_pkg::FMT_A8: p.a = lo[7:0];
			tfr8_pkg::FMT_F32X1: begin
				p.r = f32_8(lo[31:0]); p.g = f; p.b = f;
			end
			tfr8_pkg::FMT_F32X2: begin
				p.r = f32_8(lo[31:0]); p.g = f32_8(lo[63:32]); p.b = f;
			end
			tfr8_pkg::FMT_F32X4: begin
				p.r = f32_8(lo[31:0]); p.g = f32_8(lo[63:32]);
				p.b = f32_8(hi[31:0]); p.a = f32_8(hi[63:32]);
			end
			tfr8_pkg::FMT_F16X1: begin
				p.r = f16_8(lo[15:0]); p.g = f; p.b = f;
			end
			tfr8_pkg::FMT_F16X2: begin
				p.r = f16_8(lo[15:0]); p.g = f16_8(lo[31:16]); p.b = f;
			end
			tfr8_pkg::FMT_F16X4: begin
				p.r = f16_8(lo[15:0]); p.g = f16_8(lo[31:16]);
				p.b = f16_8(lo[47:32]); p.a = f16_8(lo[63:48]);
			end
			default: p = '{0, 0, 0, 0, 1'b1};
		endcase
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		pixel_t got;
		if (!arst_n) begin
			fill_on <= 1'b0;
			errors  <= 0;
		end else begin
			if (cfg_we) fill_on <= cfg_wdata;
			if (in_valid && !in_stall)
				pixel_q.push_back(decode_texel(mode, texel_low, texel_high, fill_on));
			if (out_valid && !out_stall) begin
				got = '{red, green, blue, alpha, unsupported};
				if (pixel_q.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) $display("unexpected pixel beat %h", got);
				end else begin
					want = pixel_q.pop_front();
					if (want !== got) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("pixel mismatch: exp r%h g%h b%h a%h u%b got r%h g%h b%h a%h u%b",
								want.r, want.g, want.b, want.a, want.bad,
								got.r, got.g, got.b, got.a, got.bad);
					end
				end
			end
		end
	end
endmodule

// ===== tb/testbench.sv =====
// testbench: stimulus and verdict for texel_format_to_rgba8_unit; relies on
// texel_checker for prediction and comparison, and on tfr8_pkg for format codes
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [4:0]  mode;
	logic [63:0] texel_low;
	logic [63:0] texel_high;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  red, green, blue, alpha;
	logic        unsupported;
	int          errors;
	int          pending;
	int          idle_cycles;
	int          sent;
	bit          sink_calm; // stretch with no output stalls

	texel_format_to_rgba8_unit u_top (.*);
	texel_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	// output stall: mostly short bursts, sometimes long, calm phases too
	always @(posedge clk) begin
		if (sink_calm) out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
		else if (out_stall && $urandom_range(0, 99) < 70) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 99) < 15);
	end

	always @(posedge clk) if ($urandom_range(0, 199) == 0) sink_calm <= ~sink_calm;

	function automatic logic [15:0] rand_half();
		case ($urandom_range(0, 5))
			0: return 16'h3C00 | 16'($urandom_range(0, 1)) << 15;
			1: return {1'b0, 5'h1F, 10'($urandom_range(0, 1) * $urandom)};
			2: return {1'b0, 5'd0, 10'($urandom)};
			3: return {1'b0, 5'($urandom_range(1, 14)), 10'($urandom)};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_single();
		case ($urandom_range(0, 5))
			0: return 32'h3F800000 | 32'($urandom_range(0, 1)) << 31;
			1: return {1'b0, 8'hFF, 23'($urandom_range(0, 1) * $urandom)};
			2: return {1'b0, 8'd0, 23'($urandom)};
			3: return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// one beat, held until accepted; gaps of random length in front
	task automatic send_texel(input logic [4:0] m, input logic [63:0] lo, input logic [63:0] hi);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
			($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		texel_low  <= lo;
		texel_high <= hi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic random_texel();
		logic [4:0]  m;
		logic [63:0] lo;
		logic [63:0] hi;
		m  = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		if (m >= tfr8_pkg::FMT_F32X1 && m <= tfr8_pkg::FMT_F32X4) begin
			lo = {rand_single(), rand_single()};
			hi = {rand_single(), rand_single()};
		end else if (m >= tfr8_pkg::FMT_F16X1 && m <= tfr8_pkg::FMT_F16X4) begin
			lo = {rand_half(), rand_half(), rand_half(), rand_half()};
		end
		send_texel(m, lo, hi);
	endtask

	// write missing_fill only with the pipe drained and the tail flushed
	task automatic set_fill(input logic v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 1'b0; in_valid = 1'b0;
		mode = '0; texel_low = '0; texel_high = '0;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every format, float and snorm corners
		for (int f = 0; f < 2; f++) begin
			set_fill(f[0]);
			send_texel(tfr8_pkg::FMT_RGBA8, 64'hFFFF_FFFF_00FF_00FF, 64'd0);
			send_texel(tfr8_pkg::FMT_565, 64'hFFFF, 64'd0);
			send_texel(tfr8_pkg::FMT_5551, 64'h8421, 64'd0);
			send_texel(tfr8_pkg::FMT_4444, 64'hF0F0, 64'd0);
			send_texel(tfr8_pkg::FMT_SNORM2, 64'h817F, 64'd0);
			send_texel(tfr8_pkg::FMT_SNORM4, 64'h0180_7F81, 64'd0);
			send_texel(tfr8_pkg::FMT_1010102, 64'hFFFF_FFFF, 64'd0);
			send_texel(tfr8_pkg::FMT_RG16, 64'h8000_FFFF, 64'd0);
			send_texel(tfr8_pkg::FMT_RGBA16, 64'hFFFF_0000_8000_0001, 64'd0);
			send_texel(tfr8_pkg::FMT_A8, 64'hFFFF_FFFF_FFFF_FF80, 64'd0);
			send_texel(tfr8_pkg::FMT_F32X1, 64'h3F00_0000, 64'd0);
			send_texel(tfr8_pkg::FMT_F32X2, 64'h7FC0_0000_BF80_0000, 64'd0);
			send_texel(tfr8_pkg::FMT_F32X4, 64'h7F80_0000_0000_0001,
				64'h3F7F_FFFF_8000_0000);
			send_texel(tfr8_pkg::FMT_F16X1, 64'h0001, 64'd0);
			send_texel(tfr8_pkg::FMT_F16X2, 64'h7C01_3BFF, 64'd0);
			send_texel(tfr8_pkg::FMT_F16X4, 64'h7C00_8000_3C00_3800, 64'd0);
			send_texel(5'd16, '1, '1);
			send_texel(5'd31, '1, '1);
		end

		// random phases across both fill settings
		for (int ph = 0; ph < 4; ph++) begin
			set_fill(ph[0]);
			repeat (275) random_texel();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d texel beats over formats 0..31, both fill settings", sent);
		$display("input and output gaps were randomized with calm stretches");
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/tfr8_pkg.sv
hdl/texel_format_to_rgba8_unit.sv
tb/texel_checker.sv
tb/testbench.sv
